[rtl/slist_pkg.sv]
package slist_pkg;

    localparam int OP_W    = 1;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef logic [OP_W-1:0]           op_t;
    typedef logic signed [VAL_W-1:0]   value_t;
    typedef logic [STAT_W-1:0]         status_t;
    typedef logic [COUNT_W-1:0]        count_out_t;

    localparam op_t OP_INSERT = 1'b0;
    localparam op_t OP_REMOVE = 1'b1;

    localparam status_t ST_DONE     = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_NOTFOUND = 2'd2;

endpackage

[rtl/slist_if.sv]
interface slist_req_if;
    logic                valid;
    logic                ready;
    slist_pkg::op_t      operation;
    slist_pkg::value_t   value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface slist_rsp_if;
    logic                   valid;
    logic                   ready;
    slist_pkg::status_t     status;
    slist_pkg::count_out_t  entry_count;
    slist_pkg::value_t      smallest;

    modport source (output valid, output status, output entry_count, output smallest,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input smallest,
                    output ready);
endinterface

[rtl/slist_store.sv]
module slist_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  slist_pkg::value_t  wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output slist_pkg::value_t  rd_data
);
    import slist_pkg::*;

    value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/sorted_list_insert_remove.sv]
// Sorted list of signed 32-bit values, ascending, duplicates allowed, up to
// CAPACITY entries held in a single-port-write / single-port-read RAM with a
// registered read port. A request either inserts a value (placed ahead of any
// equal entries; rejected with status FULL when the table holds CAPACITY
// entries) or removes the first equal entry (status NOTFOUND if none). Every
// request yields one response: status, entry count after the request (low 5
// bits), and the smallest value held (zero when empty). Each request that
// is not a rejected insert walks the table once, reading one entry per cycle
// and writing the shifted entry back right behind the read pointer. The
// request closes once the last read data has returned, and the response is
// registered as it closes; an empty table or a rejected insert needs no
// reads. The input reopens as the response becomes valid. A request cannot
// close while the previous response still waits in the output register,
// which stalls it. Requests are handled one at a time; a new request is
// taken while the previous response still waits in the output register.
module sorted_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    slist_req_if.sink     req,
    slist_rsp_if.source   rsp
);
    import slist_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    // control
    logic           state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  ra_reg, ra_next;       // next entry to read
    logic           pv_reg, pv_next;       // read data valid this cycle
    logic [AW-1:0]  pi_reg, pi_next;       // index of returning read data
    logic           placed_reg, placed_next;  // insert placed / remove found
    logic           dead_reg, dead_next;   // remove passed the value
    logic           rej_reg, rej_next;     // insert rejected, table full
    logic           ovalid_reg, ovalid_next;

    // payload
    op_t            op_reg;
    value_t         val_reg;
    value_t         carry_reg, carry_next;
    value_t         head_reg, head_next;
    status_t        ostat_reg, ostat_next;
    count_out_t     ocount_reg, ocount_next;
    value_t         osmall_reg, osmall_next;

    // RAM ports
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    value_t         wr_data;
    logic           rd_en;
    value_t         rd_data;

    logic           accept;
    logic           finish;
    logic           rd_ge;
    logic           rd_eq;

    slist_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ra_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // reads run ahead of write-back by at least one entry, so no read ever sees a
    // stale location
    assign rd_en  = (state_reg == S_RUN) && (ra_reg < count_reg);
    assign finish = (state_reg == S_RUN) && (ra_reg == count_reg) && !pv_reg
                    && (!ovalid_reg || rsp.ready);

    assign rd_ge = ($signed(rd_data) >= $signed(val_reg));
    assign rd_eq = (rd_data == val_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ra_next     = ra_reg;
        pv_next     = rd_en;
        pi_next     = ra_reg[AW-1:0];
        placed_next = placed_reg;
        dead_next   = dead_reg;
        rej_next    = rej_reg;
        carry_next  = carry_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        ocount_next = ocount_reg;
        osmall_next = osmall_reg;
        wr_en       = 1'b0;
        wr_addr     = pi_reg;
        wr_data     = carry_reg;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (accept)
        begin
            state_next  = S_RUN;
            placed_next = 1'b0;
            dead_next   = 1'b0;
            rej_next    = (req.operation == OP_INSERT) && (count_reg >= CAP_C);
            ra_next     = ((req.operation == OP_INSERT) && (count_reg >= CAP_C))
                          ? count_reg : '0;
        end

        if (rd_en)
        begin
            ra_next = ra_reg + 1'b1;
        end

        // returning entry: insert shifts up, remove shifts down
        if (pv_reg)
        begin
            if (op_reg == OP_INSERT)
            begin
                if (placed_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pi_reg;
                    wr_data    = carry_reg;
                    carry_next = rd_data;
                end
                else if (rd_ge)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = pi_reg;
                    wr_data     = val_reg;
                    carry_next  = rd_data;
                    placed_next = 1'b1;
                end
            end
            else
            begin
                if (placed_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pi_reg - 1'b1;
                    wr_data = rd_data;
                end
                else if (!dead_reg)
                begin
                    if (rd_eq)
                    begin
                        placed_next = 1'b1;
                    end
                    else if (rd_ge)
                    begin
                        dead_next = 1'b1;
                    end
                end
            end
        end

        if (finish)
        begin
            state_next  = S_IDLE;
            ovalid_next = 1'b1;
            if (op_reg == OP_INSERT)
            begin
                if (rej_reg)
                begin
                    ostat_next = ST_FULL;
                end
                else
                begin
                    ostat_next = ST_DONE;
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    wr_data    = placed_reg ? carry_reg : val_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (placed_reg)
                begin
                    ostat_next = ST_DONE;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    ostat_next = ST_NOTFOUND;
                end
            end
        end

        // track entry 0 so the smallest value needs no extra read
        head_next = head_reg;
        if (wr_en && (wr_addr == '0))
        begin
            head_next = wr_data;
        end

        if (finish)
        begin
            ocount_next = COUNT_W'(count_next);
            osmall_next = (count_next == '0) ? '0 : head_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ra_reg     <= '0;
            pv_reg     <= 1'b0;
            pi_reg     <= '0;
            placed_reg <= 1'b0;
            dead_reg   <= 1'b0;
            rej_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ra_reg     <= ra_next;
            pv_reg     <= pv_next;
            pi_reg     <= pi_next;
            placed_reg <= placed_next;
            dead_reg   <= dead_next;
            rej_reg    <= rej_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.operation;
            val_reg <= req.value;
        end
        carry_reg  <= carry_next;
        head_reg   <= head_next;
        ostat_reg  <= ostat_next;
        ocount_reg <= ocount_next;
        osmall_reg <= osmall_next;
    end

    assign rsp.valid       = ovalid_reg;
    assign rsp.status      = ostat_reg;
    assign rsp.entry_count = ocount_reg;
    assign rsp.smallest    = osmall_reg;

    // the count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    // write-back never lands beyond the occupied region plus the new slot
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW'(wr_addr) <= count_reg))
        else $error("RAM write outside occupied range");

    // read data only returns while a request is in progress
    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == S_RUN))
        else $error("read data returned while idle");

    // a completed request changes the count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> ((count_reg == $past(count_reg))
                    || (count_reg == $past(count_reg) + 1'b1)
                    || (count_reg == $past(count_reg) - 1'b1)))
        else $error("count changed by more than one");

endmodule

[dv/slist_result_checker.sv]
`timescale 1ns / 100ps

module slist_result_checker #(
    parameter int CAPACITY = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    slist_req_if   req,
    slist_rsp_if   rsp,
    output int     mismatches,
    output int     outstanding
);
    import slist_pkg::*;

    typedef struct packed {
        status_t    status;
        count_out_t entry_count;
        value_t     smallest;
    } list_result_t;

    value_t       held_values[$];     // ascending, duplicates kept
    list_result_t awaited_results[$];
    int           fail_total = 0;

    // Apply one request to the local copy of the table, return the response.
    function automatic list_result_t apply_list_op(input op_t op, input value_t v);
        int           pos;
        list_result_t r;
        pos = 0;
        while (pos < held_values.size() && held_values[pos] < v)
            pos++;
        if (op == OP_INSERT)
        begin
            if (held_values.size() >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                held_values.insert(pos, v);
                r.status = ST_DONE;
            end
        end
        else if (pos < held_values.size() && held_values[pos] == v)
        begin
            held_values.delete(pos);
            r.status = ST_DONE;
        end
        else
            r.status = ST_NOTFOUND;
        r.entry_count = count_out_t'(held_values.size());
        r.smallest    = (held_values.size() > 0) ? held_values[0] : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        if (!rst_n)
        begin
            held_values.delete();
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                awaited_results.push_back(apply_list_op(req.operation, req.value));
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("response with no request pending");
                    fail_total++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (rsp.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, rsp.status);
                        fail_total++;
                    end
                    if (rsp.entry_count !== exp_r.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_r.entry_count, rsp.entry_count);
                        fail_total++;
                    end
                    if (rsp.smallest !== exp_r.smallest)
                    begin
                        $error("smallest: expected %0d, got %0d",
                               exp_r.smallest, rsp.smallest);
                        fail_total++;
                    end
                end
            end
            outstanding <= awaited_results.size();
        end
        mismatches <= fail_total;
    end

endmodule

[dv/sorted_list_insert_remove_tb.sv]
`timescale 1ns / 100ps

module sorted_list_insert_remove_tb;
    import slist_pkg::*;

    localparam int CAPACITY = 16;

    // Value extremes for the signed 32-bit field
    localparam value_t VAL_MAX = 32'sh7FFF_FFFF;
    localparam value_t VAL_MIN = 32'sh8000_0000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatches;
    int outstanding;

    // Idle percentages, changed per phase by the stimulus process
    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    // Cycles the response side must hold ready low; counted down by the receiver
    int hold_cycles   = 0;

    // A few wide values reused across the run so removes of big values can hit
    value_t wide_pool[8];

    slist_req_if req();
    slist_rsp_if rsp();

    sorted_list_insert_remove #(.CAPACITY(CAPACITY)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    slist_result_checker #(.CAPACITY(CAPACITY)) u_result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Response side: random back-pressure, or a forced hold-off when requested.
    // Drives only at the falling edge so the DUT sees a stable ready.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Offer one request; entered and left at a falling edge. Valid is only
    // dropped when an idle cycle is inserted, so back-to-back requests keep it
    // high with a single assignment per time step.
    task automatic issue_request(input op_t op, input value_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.value     <= v;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every response has come back.
    task automatic drain_responses();
        req.valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    // Mostly a small cluster around zero so removes find matches and duplicates
    // pile up; some extremes, some reused wide values, some fully random.
    function automatic value_t pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return value_t'(int'($urandom_range(6)) - 3);
        else if (r < 60)
        begin
            case ($urandom_range(3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return VAL_MIN + 1;
                default: return VAL_MAX - 1;
            endcase
        end
        else if (r < 75)
            return wide_pool[$urandom_range(7)];
        else
            return value_t'($urandom);
    endfunction

    // Random traffic in bursts of 40 with an insert bias that sweeps the table
    // between empty and full, so both the full and the not-found paths recur.
    task automatic run_random(input int n_items);
        int   insert_bias;
        op_t  op;
        insert_bias = 50;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: insert_bias = 15;
                    1: insert_bias = 50;
                    default: insert_bias = 85;
                endcase
            end
            op = ($urandom_range(99) < insert_bias) ? OP_INSERT : OP_REMOVE;
            issue_request(op, pick_value());
        end
    endtask

    initial
    begin
        req.valid     = 1'b0;
        req.operation = OP_INSERT;
        req.value     = '0;
        for (int k = 0; k < 8; k++)
            wide_pool[k] = value_t'($urandom);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase 1: sender idles lightly, receiver heavily
        send_idle_pct = 22;
        rcv_idle_pct  = 64;

        // Directed: remove on empty table, extremes, duplicates, miss between
        // entries, fill to capacity, insert when full, then trim.
        issue_request(OP_REMOVE, value_t'(5));
        issue_request(OP_INSERT, VAL_MAX);
        issue_request(OP_INSERT, VAL_MIN);
        issue_request(OP_INSERT, value_t'(0));
        issue_request(OP_INSERT, value_t'(-1));
        issue_request(OP_INSERT, value_t'(0));
        issue_request(OP_REMOVE, value_t'(1));
        issue_request(OP_REMOVE, VAL_MIN);
        issue_request(OP_REMOVE, VAL_MAX);
        // three held (-1, 0, 0); thirteen more fills the table
        for (int k = 0; k < 13; k++)
            issue_request(OP_INSERT, value_t'(int'($urandom_range(20)) - 10));
        issue_request(OP_INSERT, VAL_MIN);
        issue_request(OP_REMOVE, value_t'(0));
        issue_request(OP_REMOVE, value_t'(-1));

        run_random(600);
        drain_responses();

        // Phase 2: roles swapped. Open with a long receiver hold-off while
        // requests keep coming, so the output register fills and input stalls.
        send_idle_pct = 64;
        rcv_idle_pct  = 22;
        hold_cycles   = 300;
        run_random(650);
        drain_responses();

        // Phase 3: full rate both sides
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        run_random(675);

        req.valid <= 1'b0;
        wait (outstanding == 0);
        // leave room for a stray response
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sorted_list_insert_remove.f]
rtl/slist_pkg.sv
rtl/slist_if.sv
rtl/slist_store.sv
rtl/sorted_list_insert_remove.sv
dv/slist_result_checker.sv
dv/sorted_list_insert_remove_tb.sv
